>>> rtl/elevator_request_scheduler_unit_assert.svh
// Assertion macros for the elevator request scheduler.
// Included by the top level; no other dependencies.
`ifndef ELEVATOR_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define ELEVATOR_REQUEST_SCHEDULER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ERS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elevator scheduler: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ERS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elevator scheduler: next-cycle check failed");

`endif

>>> rtl/ers_pkg.sv
// Shared types and constants of the elevator request scheduler.
// Used by ers_ctrl, ers_dp and the top level; no dependencies.
package ers_pkg;

  localparam int FLOOR_W = 6;
  localparam int COUNT_W = 6;
  localparam int CODE_W  = 3;

  // Result status codes
  localparam logic [CODE_W-1:0] ST_ACCEPTED     = 3'd0;
  localparam logic [CODE_W-1:0] ST_AGAINST_DOWN = 3'd1;
  localparam logic [CODE_W-1:0] ST_AGAINST_UP   = 3'd2;
  localparam logic [CODE_W-1:0] ST_NO_FLOOR     = 3'd3;
  localparam logic [CODE_W-1:0] ST_FULL         = 3'd4;
  localparam logic [CODE_W-1:0] ST_SERVED       = 3'd5;
  localparam logic [CODE_W-1:0] ST_IDLE         = 3'd6;

  // Heading codes
  localparam logic HEAD_UP   = 1'b0;
  localparam logic HEAD_DOWN = 1'b1;

  // Request modes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_SERVE   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_LOWEST  = 2'd0;
  localparam logic [1:0] REG_HIGHEST = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // latch incoming request, arm the scan
    logic latch_check; // store the request check code
    logic do_inc;      // count an accepted floor request
    logic scan_step;   // advance the scan pointer
    logic scan_miss;   // scan found nothing: result is idle
    logic do_take;     // serve the floor under the scan pointer
    logic load_out;    // move the result into the output register
  } ers_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mode;
    logic check_ok;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } ers_stat_t;

endpackage

>>> rtl/ers_dp.sv
// Datapath of the elevator request scheduler: car state, per-floor count
// memory with valid bits, scan pointer and output register. Uses ers_pkg.
module ers_dp import ers_pkg::*; #(
  parameter int FLOOR_SLOTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ers_cmd_t                  cmd,
  output ers_stat_t                 stat,
  input  logic                      in_mode,
  input  logic signed [FLOOR_W-1:0] in_target,
  input  logic signed [FLOOR_W-1:0] lowest_floor,
  input  logic signed [FLOOR_W-1:0] highest_floor,
  input  logic        [COUNT_W-1:0] rider_limit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [CODE_W-1:0]  out_status,
  output logic signed [FLOOR_W-1:0] out_floor_now,
  output logic        [COUNT_W-1:0] out_riders_left_car,
  output logic        [COUNT_W-1:0] out_riders_aboard,
  output logic                      out_heading
);

  // Only slots of floors -32..31 are ever used
  localparam int SLOT_N = (FLOOR_SLOTS < 64) ? FLOOR_SLOTS : 64;
  localparam int SW     = $clog2(SLOT_N);

  logic                      mode_r;
  logic signed [FLOOR_W-1:0] target_r;
  logic        [COUNT_W-1:0] total_r;
  logic signed [FLOOR_W-1:0] car_floor_r;
  logic                      heading_r;
  logic [SLOT_N-1:0]         nz_r;
  logic [SW-1:0]             scan_idx_r;
  logic [SW-1:0]             scan_idx_nxt;
  logic [CODE_W-1:0]         res_code_r;
  logic [COUNT_W-1:0]        left_r;
  logic [COUNT_W-1:0]        rdata_r;
  logic [COUNT_W-1:0]        cnt_mem [SLOT_N];
  logic                      out_valid_r;
  logic [CODE_W-1:0]         out_status_r;
  logic signed [FLOOR_W-1:0] out_floor_r;
  logic [COUNT_W-1:0]        out_left_r;
  logic [COUNT_W-1:0]        out_aboard_r;
  logic                      out_heading_r;

  logic [FLOOR_W-1:0]        req_s6;
  logic                      req_exists;
  logic [SW-1:0]             req_slot;
  logic [SW-1:0]             mem_raddr;
  logic [CODE_W-1:0]         check_code;
  logic [COUNT_W-1:0]        cur_cnt;
  logic [FLOOR_W-1:0]        scan_s6;
  logic signed [FLOOR_W-1:0] scan_floor;
  logic                      out_free;

  // Slot of the requested floor is floor + 32
  assign req_s6     = {~target_r[FLOOR_W-1], target_r[FLOOR_W-2:0]};
  assign req_exists = ({1'b0, req_s6} < (FLOOR_W+1)'(SLOT_N));
  assign req_slot   = req_s6[SW-1:0];
  assign mem_raddr  = (mode_r == MODE_SERVE) ? scan_idx_r : req_slot;

  // Floor under the scan pointer
  assign scan_s6    = FLOOR_W'(scan_idx_r);
  assign scan_floor = {~scan_s6[FLOOR_W-1], scan_s6[FLOOR_W-2:0]};

  // A slot whose valid bit is clear holds zero riders
  assign cur_cnt = nz_r[req_slot] ? rdata_r : '0;

  // Request checks in priority order
  always_comb begin
    if (total_r >= rider_limit) begin
      check_code = ST_FULL;
    end else if (total_r != '0 && heading_r == HEAD_DOWN && target_r > car_floor_r) begin
      check_code = ST_AGAINST_DOWN;
    end else if (total_r != '0 && heading_r == HEAD_UP && target_r < car_floor_r) begin
      check_code = ST_AGAINST_UP;
    end else if (target_r > highest_floor || target_r < lowest_floor || !req_exists) begin
      check_code = ST_NO_FLOOR;
    end else begin
      check_code = ST_ACCEPTED;
    end
  end

  // Scan pointer: start at the bottom heading up, at the top heading down
  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (cmd.accept) begin
      scan_idx_nxt = (heading_r == HEAD_UP) ? '0 : SW'(SLOT_N - 1);
    end else if (cmd.scan_step) begin
      scan_idx_nxt = (heading_r == HEAD_UP) ? scan_idx_r + 1'b1 : scan_idx_r - 1'b1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign stat.mode      = mode_r;
  assign stat.check_ok  = (check_code == ST_ACCEPTED);
  assign stat.scan_hit  = nz_r[scan_idx_r];
  assign stat.scan_last = (heading_r == HEAD_UP) ? (scan_idx_r == SW'(SLOT_N - 1))
                                                 : (scan_idx_r == '0);
  assign stat.out_free  = out_free;

  // Count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_inc) begin
      cnt_mem[req_slot] <= cur_cnt + 1'b1;
    end
    rdata_r <= cnt_mem[mem_raddr];
  end

  // Request latch and result staging
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    if (cmd.accept) begin
      mode_r   <= in_mode;
      target_r <= in_target;
      left_r   <= '0;
    end
    if (cmd.latch_check) begin
      res_code_r <= check_code;
    end
    if (cmd.scan_miss) begin
      res_code_r <= ST_IDLE;
    end
    if (cmd.do_take) begin
      res_code_r <= ST_SERVED;
      left_r     <= rdata_r;
    end
  end

  // Car state and slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      car_floor_r <= '0;
      heading_r   <= HEAD_UP;
      nz_r        <= '0;
    end else if (cmd.do_inc) begin
      nz_r[req_slot] <= 1'b1;
      total_r        <= total_r + 1'b1;
      if (total_r == '0) begin
        if (target_r > car_floor_r) begin
          heading_r <= HEAD_UP;
        end else if (target_r < car_floor_r) begin
          heading_r <= HEAD_DOWN;
        end
      end
    end else if (cmd.do_take) begin
      nz_r[scan_idx_r] <= 1'b0;
      total_r          <= total_r - rdata_r;
      car_floor_r      <= scan_floor;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_code_r;
      out_floor_r   <= car_floor_r;
      out_left_r    <= left_r;
      out_aboard_r  <= total_r;
      out_heading_r <= heading_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_floor_now       = out_floor_r;
  assign out_riders_left_car = out_left_r;
  assign out_riders_aboard   = out_aboard_r;
  assign out_heading         = out_heading_r;

endmodule

>>> rtl/ers_ctrl.sv
// Controller of the elevator request scheduler: sequences check, count
// update, floor scan and result hand-off. Uses ers_pkg.
module ers_ctrl import ers_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ers_stat_t stat,
  output ers_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INC   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TAKE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        // latched mode is visible from here on
        if (stat.mode == MODE_SERVE) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.latch_check = 1'b1;
          state_nxt       = stat.check_ok ? S_INC : S_DONE;
        end
      end
      S_INC: begin
        cmd.do_inc = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = S_TAKE;
        end else if (stat.scan_last) begin
          cmd.scan_miss = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TAKE: begin
        cmd.do_take = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/elevator_request_scheduler_unit.sv
// Elevator request scheduler for one car: input and result streams,
// configuration port and request sequencing.
// Channels: in_* carries requests (in_tuser = mode, in_tdata = target floor);
// out_* carries one result per request (out_tuser = status, out_tdata holds
// floor now, riders who left, riders aboard and heading). cfg_* is an
// APB-style port for lowest floor (0x0), highest floor (0x4) and rider
// limit (0x8); write it only while no request is in flight.
// Requests are handled one at a time. A floor request goes from S_CHECK
// through S_INC to S_DONE when counted, and straight to S_DONE when refused.
// A serve request goes through S_CHECK and S_SCAN, then S_TAKE on a hit, to
// S_DONE; the scan steps over up to min(FLOOR_SLOTS,64) floor slots, reading
// one slot valid bit per cycle and then one word of the count memory.
// A finished result sits in the output register; the next request is taken
// while it waits, but that request's result is held until the receiver
// takes the previous one (out_tready high).
// Reset (rst_n low, synchronous) empties the car, clears all floor counts
// through their valid bits, puts the car at floor 0 heading up and
// restores register defaults 0, 31 and 8.
`include "elevator_request_scheduler_unit_assert.svh"

module elevator_request_scheduler_unit import ers_pkg::*; #(
  parameter int FLOOR_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [5:0] target_floor, [7:6] zero
  input  logic [0:0]  in_tuser,    // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [5:0] floor_now, [11:6] riders_left_car,
                                   // [17:12] riders_aboard, [18] heading, [23:19] zero
  output logic [2:0]  out_tuser,   // [2:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ers_cmd_t                  cmd;
  ers_stat_t                 stat;
  logic signed [FLOOR_W-1:0] lowest_r;
  logic signed [FLOOR_W-1:0] highest_r;
  logic        [COUNT_W-1:0] limit_r;
  logic                      cfg_wr;
  logic signed [FLOOR_W-1:0] floor_now;
  logic        [COUNT_W-1:0] left_car;
  logic        [COUNT_W-1:0] aboard;
  logic                      heading;
  logic        [CODE_W-1:0]  status;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= 6'sd0;
      highest_r <= 6'sd31;
      limit_r   <= 6'd8;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_LOWEST:  lowest_r  <= cfg_pwdata[FLOOR_W-1:0];
        REG_HIGHEST: highest_r <= cfg_pwdata[FLOOR_W-1:0];
        REG_LIMIT:   limit_r   <= cfg_pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LOWEST:  cfg_prdata = {26'd0, lowest_r};
      REG_HIGHEST: cfg_prdata = {26'd0, highest_r};
      REG_LIMIT:   cfg_prdata = {26'd0, limit_r};
      default:     cfg_prdata = '0;
    endcase
  end

  ers_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ers_dp #(
    .FLOOR_SLOTS (FLOOR_SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_mode             (in_tuser[0]),
    .in_target           (in_tdata[FLOOR_W-1:0]),
    .lowest_floor        (lowest_r),
    .highest_floor       (highest_r),
    .rider_limit         (limit_r),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_status          (status),
    .out_floor_now       (floor_now),
    .out_riders_left_car (left_car),
    .out_riders_aboard   (aboard),
    .out_heading         (heading)
  );

  assign out_tuser = status;
  assign out_tdata = {5'd0, heading, aboard, left_car, floor_now};

  // One request in flight at a time
  `ERS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A served stop always lets riders out
  `ERS_ASSERT_SAME(a_served_has_riders, clk, rst_n,
    out_tvalid && out_tuser == ST_SERVED, out_tdata[11:6] != 6'd0)
  // Nobody leaves the car on any other result
  `ERS_ASSERT_SAME(a_no_exit_otherwise, clk, rst_n,
    out_tvalid && out_tuser != ST_SERVED, out_tdata[11:6] == 6'd0)

endmodule
